FILE: sv/binary_edge_detector_unit_macros.svh
// Assertion helpers for the checker of this block.
`ifndef BINARY_EDGE_DETECTOR_UNIT_MACROS_SVH
`define BINARY_EDGE_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define BED_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, active during reset as well.
`define BED_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/bed_pkg.sv
`default_nettype none

package bed_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_THRESHOLD = 2'd2;

    localparam logic [10:0] RST_IMAGE_WIDTH     = 11'd640;
    localparam logic [12:0] RST_IMAGE_HEIGHT    = 13'd480;
    localparam logic [7:0]  RST_BLACK_THRESHOLD = 8'd128;

    // Output pixel codes
    localparam logic [7:0] PIX_EDGE = 8'd0;
    localparam logic [7:0] PIX_FLAT = 8'd255;

    // Entries of the queue between front and back
    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] edge_pixel;
        logic       frame_end;
    } t_res_out;

    // Per-pixel classification handed from the front to the back.
    typedef struct packed {
        logic pix_bit;
        logic top_row;
        logic left_col;
        logic frame_end;
    } t_cls_flags;

    localparam int CLS_FLAGS_W = $bits(t_cls_flags);

endpackage

`default_nettype wire

FILE: sv/bed_front.sv
`default_nettype none

module bed_front import bed_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  wire logic                         i_pix_valid,
    input  wire t_pix_in                      i_pix,
    output logic                              o_pix_stall,
    input  wire logic                         i_q_full,
    output logic                              o_q_push,
    output t_cls_flags                        o_q_flags,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_q_col
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WCW = (CW + 1 > 11) ? CW + 1 : 11;
    localparam int HCW = (RW + 1 > 13) ? RW + 1 : 13;

    logic [10:0]   r_width;
    logic [12:0]   r_height;
    logic [7:0]    r_thr;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;

    logic [9:0]     sum;
    logic [9:0]     thr3;
    logic [WCW-1:0] w_cfg;
    logic [WCW-1:0] w_eff;
    logic [HCW-1:0] h_cfg;
    logic [HCW-1:0] h_eff;
    logic           last_col;
    logic           last_row;
    logic           accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_IMAGE_WIDTH;
            r_height <= RST_IMAGE_HEIGHT;
            r_thr    <= RST_BLACK_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH:     r_width  <= i_cfg_data[10:0];
                REG_IMAGE_HEIGHT:    r_height <= i_cfg_data[12:0];
                REG_BLACK_THRESHOLD: r_thr    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        // The mean (r+g+b)/3 is at most thr exactly when r+g+b <= 3*thr+2.
        sum  = 10'(i_pix.red_in) + 10'(i_pix.green_in) + 10'(i_pix.blue_in);
        thr3 = 10'({r_thr, 1'b0}) + 10'(r_thr) + 10'd2;

        w_cfg = WCW'(r_width);
        if (w_cfg < WCW'(2)) begin
            w_eff = WCW'(2);
        end else if (w_cfg > WCW'(MAX_WIDTH)) begin
            w_eff = WCW'(MAX_WIDTH);
        end else begin
            w_eff = w_cfg;
        end

        h_cfg = HCW'(r_height);
        if (h_cfg < HCW'(2)) begin
            h_eff = HCW'(2);
        end else if (h_cfg > HCW'(MAX_HEIGHT)) begin
            h_eff = HCW'(MAX_HEIGHT);
        end else begin
            h_eff = h_cfg;
        end

        last_col = (WCW'(r_col) + WCW'(1)) >= w_eff;
        last_row = (HCW'(r_row) + HCW'(1)) >= h_eff;

        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    assign o_pix_stall = i_q_full;
    assign accept      = i_pix_valid && !i_q_full;

    assign o_q_push            = accept;
    assign o_q_col             = r_col;
    assign o_q_flags.pix_bit   = sum > thr3;
    assign o_q_flags.top_row   = r_row == '0;
    assign o_q_flags.left_col  = r_col == '0;
    assign o_q_flags.frame_end = last_col && last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

FILE: sv/bed_queue.sv
`default_nettype none

module bed_queue import bed_pkg::*; #(
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_valid,
    output logic [DW-1:0]      o_rdata
);

    localparam int PW = $clog2(Q_DEPTH);

    logic [DW-1:0] r_mem [Q_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [PW:0]   r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = r_count == (PW+1)'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_rdata = r_mem[r_rptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/bed_back.sv
`default_nettype none

module bed_back import bed_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_valid,
    input  wire t_cls_flags                   i_q_flags,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] i_q_col,
    output logic                              o_q_pop,
    output logic                              o_res_valid,
    output t_res_out                          o_res,
    input  wire logic                         i_res_stall
);

    localparam int CW = $clog2(MAX_WIDTH);

    // Line store: one bit per column of the previous row.
    logic          r_line [MAX_WIDTH];
    logic          r_above;
    // Columns below this count have been written since reset.
    logic [CW:0]   r_fill;
    logic          r_left;

    logic          r_s1_vld;
    logic          r_s1_bit;
    logic          r_s1_top;
    logic          r_s1_fe;
    logic          r_s1_ledge;
    logic          r_s1_avld;

    logic          r_o_vld;
    t_res_out      r_res;
    t_res_out      n_res;

    logic          s2_take;
    logic          s1_ready;
    logic          pop;
    logic [CW:0]   col_p1;
    logic          above;

    assign s2_take  = !r_o_vld || !i_res_stall;
    assign s1_ready = !r_s1_vld || s2_take;
    assign pop      = i_q_valid && s1_ready;
    assign o_q_pop  = pop;
    assign col_p1   = (CW+1)'(i_q_col) + (CW+1)'(1);

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_above           <= r_line[i_q_col];
            r_line[i_q_col]   <= i_q_flags.pix_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_left <= 1'b0;
        end else if (pop) begin
            if (col_p1 > r_fill) begin
                r_fill <= col_p1;
            end
            r_left <= i_q_flags.pix_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_ready) begin
            r_s1_vld <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s1_bit   <= i_q_flags.pix_bit;
            r_s1_top   <= i_q_flags.top_row;
            r_s1_fe    <= i_q_flags.frame_end;
            r_s1_ledge <= !i_q_flags.left_col && (r_left != i_q_flags.pix_bit);
            r_s1_avld  <= (CW+1)'(i_q_col) < r_fill;
        end
    end

    always_comb begin
        // A column never written since reset reads as zero.
        above           = r_s1_avld && r_above;
        n_res.frame_end = r_s1_fe;
        if (r_s1_ledge || (!r_s1_top && (above != r_s1_bit))) begin
            n_res.edge_pixel = PIX_EDGE;
        end else begin
            n_res.edge_pixel = PIX_FLAT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (s2_take) begin
            r_o_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_take && r_s1_vld) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_o_vld;
    assign o_res       = r_res;

endmodule

`default_nettype wire

FILE: sv/binary_edge_detector_unit.sv
// Binary threshold edge detector for an RGB pixel stream in raster order.
// Input channel: i_pix_valid with the word i_pix (red, green, blue); the block
// pushes back with o_pix_stall. Output channel: o_res_valid with the word o_res
// (edge_pixel is 0 on an edge and 255 elsewhere, frame_end marks the last pixel
// of a frame); the receiver pushes back with i_res_stall.
// The configuration port writes image_width, image_height and black_threshold
// by index; the user must do so only while no pixel is in flight (no guard in the block).
// Throughput is one pixel per clock while i_res_stall is low. The front
// thresholds the pixel and tracks row and column in the accepting cycle; the
// back reads and rewrites the one-bit line store through a single port once per
// pixel, with the read data registered; results pass queue, s1 and output reg.
// A four-word queue between front and back absorbs output stalls; o_pix_stall
// rises only once it is full, and pending results stay in order.
// Synchronous reset sets the sizes to 640x480, the threshold to 128 and the
// counters to zero. The line store is not swept: a fill count makes columns not
// yet written read as zero, so pixels are accepted right after reset.
`default_nettype none

module binary_edge_detector_unit import bed_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_pix_valid,
    input  wire t_pix_in               i_pix,
    output logic                       o_pix_stall,
    output logic                       o_res_valid,
    output t_res_out                   o_res,
    input  wire logic                  i_res_stall
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int DW = CLS_FLAGS_W + CW;

    logic          q_full;
    logic          q_push;
    t_cls_flags    q_wflags;
    logic [CW-1:0] q_wcol;
    logic [DW-1:0] q_rdata;
    logic          q_valid;
    logic          q_pop;
    t_cls_flags    q_rflags;
    logic [CW-1:0] q_rcol;

    bed_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_pix_valid (i_pix_valid),
        .i_pix       (i_pix),
        .o_pix_stall (o_pix_stall),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_flags   (q_wflags),
        .o_q_col     (q_wcol)
    );

    bed_queue #(
        .DW (DW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata ({q_wflags, q_wcol}),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rdata (q_rdata)
    );

    assign q_rflags = t_cls_flags'(q_rdata[DW-1 -: CLS_FLAGS_W]);
    assign q_rcol   = q_rdata[CW-1:0];

    bed_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_flags   (q_rflags),
        .i_q_col     (q_rcol),
        .o_q_pop     (q_pop),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_res_stall (i_res_stall)
    );

endmodule

`default_nettype wire

FILE: sv/bed_checker.sv
`default_nettype none

`include "binary_edge_detector_unit_macros.svh"

module bed_checker import bed_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     o_res_valid,
    input  wire t_res_out o_res,
    input  wire logic     i_res_stall
);

    // A result held back by the receiver stays put until taken.
    `BED_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n && o_res_valid && i_res_stall, !i_rst_n || (o_res_valid && $stable(o_res)), "stalled result word changed or vanished")

    // Reset empties the pipeline, so nothing is shown in the next cycle.
    `BED_ASSERT_NEXT(a_rst_empty, i_clk, !i_rst_n, !o_res_valid, "result valid right after reset")

    // The output pixel is black or white, nothing in between.
    `BED_ASSERT_NOW(a_pix_code, i_clk, i_rst_n, o_res_valid, o_res.edge_pixel == PIX_EDGE || o_res.edge_pixel == PIX_FLAT, "edge pixel is neither 0 nor 255")

endmodule

bind binary_edge_detector_unit bed_checker u_bed_checker (.*);

`default_nettype wire
